// File: rtl/healpix_ring_pixel_index_defines.svh
// Assertion helpers for the ring pixel index block.
`ifndef HEALPIX_RING_PIXEL_INDEX_DEFINES_SVH
`define HEALPIX_RING_PIXEL_INDEX_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define HPRI_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define HPRI_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hpri_pkg.sv
package hpri_pkg;

    localparam int ANGLE_BITS   = 24;
    localparam int NSIDE_W      = 14;
    localparam int NSIDE_MAX    = 8192;
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 34;
    localparam int SQRT_STEPS   = 30;
    localparam int Z_ONE        = 1073741824;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    // atan(2^-i) with 2^30 standing for a quarter turn.
    localparam logic signed [CORDIC_W-1:0] ARC_TAB [CORDIC_ITERS] = '{
        34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4, 34'sh028B0D43,
        34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55, 34'sh0028BE53, 34'sh00145F2F,
        34'sh000A2F98, 34'sh000517CC, 34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA,
        34'sh0000517D, 34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
        34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051, 34'sh00000029,
        34'sh00000014, 34'sh0000000A, 34'sh00000005, 34'sh00000003, 34'sh00000001
    };

    typedef enum logic [1:0] {
        REGION_NORTH = 2'd0,
        REGION_BELT  = 2'd1,
        REGION_SOUTH = 2'd2
    } t_region;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] ra;
        logic [31:0]           ang;
        logic [NSIDE_W-1:0]    n;
    } t_item;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] ra;
        logic [NSIDE_W-1:0]    n;
        logic [CORDIC_W-1:0]   y;
    } t_zitem;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [NSIDE_W-1:0] nside_eff(input logic [NSIDE_W-1:0] v);
        logic [NSIDE_W-1:0] r;
        if (v == '0) begin
            r = NSIDE_W'(1);
        end else if (v > NSIDE_W'(NSIDE_MAX)) begin
            r = NSIDE_W'(NSIDE_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/hpri_front.sv
module hpri_front import hpri_pkg::*; (
    input  logic                  i_start,
    input  logic [ANGLE_BITS-1:0] i_ra_turn,
    input  logic [ANGLE_BITS:0]   i_dec_quarter,
    input  logic [NSIDE_W-1:0]    i_nside,
    input  t_qstat                i_qstat,
    output logic                  o_push,
    output t_item                 o_item
);

    localparam logic signed [ANGLE_BITS:0] D_MAX = $signed({2'b01, {(ANGLE_BITS-1){1'b0}}});
    localparam logic signed [ANGLE_BITS:0] D_MIN = -D_MAX;
    localparam int SHL = (ANGLE_BITS <= 31) ? (31 - ANGLE_BITS) : 0;
    localparam int SHR = (ANGLE_BITS > 31) ? (ANGLE_BITS - 31) : 0;

    logic signed [ANGLE_BITS:0] dec_c;
    logic signed [33:0]         dec_ext;

    always_comb begin
        // Declinations past either pole sit on the pole.
        if ($signed(i_dec_quarter) > D_MAX) begin
            dec_c = D_MAX;
        end else if ($signed(i_dec_quarter) < D_MIN) begin
            dec_c = D_MIN;
        end else begin
            dec_c = $signed(i_dec_quarter);
        end
        dec_ext     = 34'(dec_c);
        o_item.ra   = i_ra_turn;
        o_item.ang  = 32'((dec_ext <<< SHL) >>> SHR);
        o_item.n    = nside_eff(i_nside);
        o_push      = i_start && !i_qstat.full;
    end

endmodule

// File: rtl/hpri_queue.sv
module hpri_queue import hpri_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    output logic   o_valid,
    output t_item  o_item,
    output t_qstat o_stat
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              pop;

    // The back end never stalls, so the head leaves as soon as it is there.
    assign pop          = (r_cnt != '0);
    assign o_valid      = pop;
    assign o_item       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// File: rtl/hpri_cordic.sv
module hpri_cordic import hpri_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_item  i_item,
    output logic   o_valid,
    output t_zitem o_z
);

    typedef struct packed {
        logic [ANGLE_BITS-1:0] ra;
        logic [NSIDE_W-1:0]    n;
        logic [CORDIC_W-1:0]   x;
        logic [CORDIC_W-1:0]   y;
        logic [CORDIC_W-1:0]   r;
    } t_cstage;

    t_cstage               r_st [CORDIC_ITERS+1];
    t_cstage               n_st [CORDIC_ITERS+1];
    logic [CORDIC_ITERS:0] r_vld;

    always_comb begin
        n_st[0].ra = i_item.ra;
        n_st[0].n  = i_item.n;
        n_st[0].x  = CORDIC_GAIN_INV;
        n_st[0].y  = '0;
        n_st[0].r  = CORDIC_W'($signed(i_item.ang));
        // One rotation per stage, direction from the sign of the residual angle.
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            n_st[i+1].ra = r_st[i].ra;
            n_st[i+1].n  = r_st[i].n;
            if (!r_st[i].r[CORDIC_W-1]) begin
                n_st[i+1].x = $signed(r_st[i].x) - ($signed(r_st[i].y) >>> i);
                n_st[i+1].y = $signed(r_st[i].y) + ($signed(r_st[i].x) >>> i);
                n_st[i+1].r = $signed(r_st[i].r) - ARC_TAB[i];
            end else begin
                n_st[i+1].x = $signed(r_st[i].x) + ($signed(r_st[i].y) >>> i);
                n_st[i+1].y = $signed(r_st[i].y) - ($signed(r_st[i].x) >>> i);
                n_st[i+1].r = $signed(r_st[i].r) + ARC_TAB[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= CORDIC_ITERS; i++) begin
            r_st[i] <= n_st[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CORDIC_ITERS-1:0], i_valid};
        end
    end

    assign o_valid = r_vld[CORDIC_ITERS];
    assign o_z.ra  = r_st[CORDIC_ITERS].ra;
    assign o_z.n   = r_st[CORDIC_ITERS].n;
    assign o_z.y   = r_st[CORDIC_ITERS].y;

endmodule

// File: rtl/hpri_finish.sv
module hpri_finish import hpri_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_zitem      i_z,
    output logic        o_valid,
    output logic [29:0] o_pixel,
    output logic [14:0] o_ring,
    output t_region     o_region
);

    localparam int FB     = ANGLE_BITS - 2;
    localparam int RA_SHL = 34 - ANGLE_BITS;
    localparam int RAD_W  = 2 * SQRT_STEPS;
    localparam int RAIR_W = ANGLE_BITS + NSIDE_W;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] ra;
        logic [NSIDE_W-1:0]    n;
        logic                  belt;
        logic                  zpos;
        logic [48:0]           t1;
        logic [47:0]           t2;
        logic [RAD_W-1:0]      rad;
        logic [SQRT_STEPS-1:0] root;
        logic [31:0]           rem;
    } t_sq;

    // Stage 1: clamp z, classify, belt products, cap radicand.
    logic signed [31:0] zc;
    logic [30:0]        za;
    logic [32:0]        za3;
    logic [30:0]        zdif;
    logic [31:0]        w3;
    logic [34:0]        base;
    logic [15:0]        n3;

    t_sq                   r_sq [SQRT_STEPS+1];
    t_sq                   n_sq [SQRT_STEPS+1];
    logic [SQRT_STEPS:0]   r_sv;
    logic [32:0]           sq_rsh   [SQRT_STEPS];
    logic [32:0]           sq_trial [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] sq_ge;

    always_comb begin
        if ($signed(i_z.y) > CORDIC_W'(Z_ONE)) begin
            zc = 32'(Z_ONE);
        end else if ($signed(i_z.y) < -CORDIC_W'(Z_ONE)) begin
            zc = -32'(Z_ONE);
        end else begin
            zc = 32'($signed(i_z.y));
        end
        za   = zc[31] ? 31'(-zc) : 31'(zc);
        za3  = 33'({za, 1'b0}) + 33'(za);
        zdif = 31'(Z_ONE) - za;
        w3   = 32'({zdif, 1'b0}) + 32'(zdif);
        base = (35'd1 << 31) + (35'(i_z.ra) << RA_SHL);
        n3   = 16'({i_z.n, 1'b0}) + 16'(i_z.n);

        n_sq[0].ra   = i_z.ra;
        n_sq[0].n    = i_z.n;
        // |z| exactly 2/3 stays in the belt.
        n_sq[0].belt = (za3 <= (33'(Z_ONE) << 1));
        n_sq[0].zpos = !zc[31] && (zc != '0);
        n_sq[0].t1   = 49'(i_z.n) * 49'(base);
        n_sq[0].t2   = 48'($signed({32'd0, n3}) * 48'(zc));
        n_sq[0].rad  = {w3[SQRT_STEPS-1:0], SQRT_STEPS'(0)};
        n_sq[0].root = '0;
        n_sq[0].rem  = '0;

        // Square root, one result bit per stage.
        for (int k = 0; k < SQRT_STEPS; k++) begin
            sq_rsh[k]   = {r_sq[k].rem[30:0], r_sq[k].rad[RAD_W-1 -: 2]};
            sq_trial[k] = {1'b0, r_sq[k].root, 2'b01};
            sq_ge[k]    = (sq_rsh[k] >= sq_trial[k]);
            n_sq[k+1]      = r_sq[k];
            n_sq[k+1].rad  = r_sq[k].rad << 2;
            n_sq[k+1].root = {r_sq[k].root[SQRT_STEPS-2:0], sq_ge[k]};
            n_sq[k+1].rem  = sq_ge[k] ? 32'(sq_rsh[k] - sq_trial[k]) : 32'(sq_rsh[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= SQRT_STEPS; k++) begin
            r_sq[k] <= n_sq[k];
        end
    end

    // Post stages P1..P5.
    logic [4:0] r_pv;

    logic signed [49:0] dif;
    logic signed [49:0] smm;
    logic [17:0]           r_p1_jp, r_p1_jm;
    logic [43:0]           r_p1_t;
    logic [ANGLE_BITS-1:0] r_p1_ra;
    logic [NSIDE_W-1:0]    r_p1_n;
    logic                  r_p1_belt, r_p1_zpos;

    always_comb begin
        dif = $signed({1'b0, r_sq[SQRT_STEPS].t1}) - 50'($signed(r_sq[SQRT_STEPS].t2));
        smm = $signed({1'b0, r_sq[SQRT_STEPS].t1}) + 50'($signed(r_sq[SQRT_STEPS].t2));
    end

    always_ff @(posedge i_clk) begin
        r_p1_jp   <= dif[49:32];
        r_p1_jm   <= smm[49:32];
        r_p1_t    <= 44'(r_sq[SQRT_STEPS].n) * 44'(r_sq[SQRT_STEPS].root);
        r_p1_ra   <= r_sq[SQRT_STEPS].ra;
        r_p1_n    <= r_sq[SQRT_STEPS].n;
        r_p1_belt <= r_sq[SQRT_STEPS].belt;
        r_p1_zpos <= r_sq[SQRT_STEPS].zpos;
    end

    logic signed [20:0] ir_raw, ir_hi, vraw, vc;
    logic [14:0]        ir_b;
    logic [18:0]        xv;
    logic [15:0]        n4_p1;
    logic [FB:0]        tpm;
    logic [14:0]           r_p2_ir_b;
    logic [15:0]           r_p2_ip_b;
    logic [FB+21:0]        r_p2_hp, r_p2_lp;
    logic [FB+22:0]        r_p2_hm, r_p2_lm;
    logic [ANGLE_BITS-1:0] r_p2_ra;
    logic [NSIDE_W-1:0]    r_p2_n;
    logic                  r_p2_belt, r_p2_zpos;

    always_comb begin
        ir_raw = $signed({7'd0, r_p1_n}) + 21'sd1 + $signed({3'd0, r_p1_jp})
                 - $signed({3'd0, r_p1_jm});
        ir_hi  = $signed({6'd0, r_p1_n, 1'b0}) + 21'sd1;
        if (ir_raw < 21'sd1) begin
            ir_b = 15'd1;
        end else if (ir_raw > ir_hi) begin
            ir_b = 15'(ir_hi);
        end else begin
            ir_b = 15'(ir_raw);
        end
        // Rings of even number start half a pixel further on.
        vraw = $signed({3'd0, r_p1_jp}) + $signed({3'd0, r_p1_jm})
               - $signed({7'd0, r_p1_n}) + $signed({20'd0, ~ir_b[0]}) + 21'sd1;
        vc    = vraw[20] ? 21'sd0 : vraw;
        xv    = vc[19:1];
        n4_p1 = {r_p1_n, 2'b00};
        tpm   = {1'b1, FB'(0)} - {1'b0, r_p1_ra[FB-1:0]};
    end

    always_ff @(posedge i_clk) begin
        r_p2_ir_b <= ir_b;
        r_p2_ip_b <= (xv >= 19'(n4_p1)) ? 16'(xv - 19'(n4_p1)) : 16'(xv);
        r_p2_hp   <= (FB+22)'(r_p1_ra[FB-1:0]) * (FB+22)'(r_p1_t[43:22]);
        r_p2_lp   <= (FB+22)'(r_p1_ra[FB-1:0]) * (FB+22)'(r_p1_t[21:0]);
        r_p2_hm   <= (FB+23)'(tpm) * (FB+23)'(r_p1_t[43:22]);
        r_p2_lm   <= (FB+23)'(tpm) * (FB+23)'(r_p1_t[21:0]);
        r_p2_ra   <= r_p1_ra;
        r_p2_n    <= r_p1_n;
        r_p2_belt <= r_p1_belt;
        r_p2_zpos <= r_p1_zpos;
    end

    logic [FB+22:0]        sp;
    logic [FB+23:0]        sm;
    logic [15:0]           irc_raw;
    logic [27:0]           r_p3_nn1;
    logic [30:0]           r_p3_irn4;
    logic [15:0]           r_p3_ip_b;
    logic [14:0]           r_p3_ir_b;
    logic [NSIDE_W-1:0]    r_p3_irc;
    logic [ANGLE_BITS-1:0] r_p3_ra;
    logic [NSIDE_W-1:0]    r_p3_n;
    logic                  r_p3_belt, r_p3_zpos;

    always_comb begin
        sp      = (FB+23)'(r_p2_hp) + (FB+23)'(r_p2_lp >> 22);
        sm      = (FB+24)'(r_p2_hm) + (FB+24)'(r_p2_lm >> 22);
        irc_raw = 16'(sp >> (FB + 8)) + 16'(sm >> (FB + 8)) + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        r_p3_nn1  <= 28'(r_p2_n) * 28'(r_p2_n - NSIDE_W'(1));
        r_p3_irn4 <= 31'(r_p2_ir_b - 15'd1) * 31'({r_p2_n, 2'b00});
        r_p3_ip_b <= r_p2_ip_b;
        r_p3_ir_b <= r_p2_ir_b;
        r_p3_irc  <= (irc_raw > 16'(r_p2_n)) ? r_p2_n : NSIDE_W'(irc_raw);
        r_p3_ra   <= r_p2_ra;
        r_p3_n    <= r_p2_n;
        r_p3_belt <= r_p2_belt;
        r_p3_zpos <= r_p2_zpos;
    end

    logic [31:0]        r_p4_pix_b;
    logic [15:0]        r_p4_ring_b;
    logic [RAIR_W-1:0]  r_p4_rair;
    logic [27:0]        r_p4_aa, r_p4_bb;
    logic [26:0]        r_p4_nn;
    logic [NSIDE_W-1:0] r_p4_irc, r_p4_n;
    logic               r_p4_belt, r_p4_zpos;

    always_ff @(posedge i_clk) begin
        r_p4_pix_b  <= 32'({r_p3_nn1, 1'b0}) + 32'(r_p3_irn4) + 32'(r_p3_ip_b);
        r_p4_ring_b <= 16'(r_p3_n) - 16'd1 + 16'(r_p3_ir_b);
        r_p4_rair   <= RAIR_W'(r_p3_ra) * RAIR_W'(r_p3_irc);
        r_p4_aa     <= 28'(r_p3_irc) * (28'(r_p3_irc) - 28'd1);
        r_p4_bb     <= 28'(r_p3_irc) * (28'(r_p3_irc) + 28'd1);
        r_p4_nn     <= 27'(r_p3_n) * 27'(r_p3_n);
        r_p4_irc    <= r_p3_irc;
        r_p4_n      <= r_p3_n;
        r_p4_belt   <= r_p3_belt;
        r_p4_zpos   <= r_p3_zpos;
    end

    logic [15:0] ipc;
    logic [31:0] pix_n, pix_s;
    logic [15:0] ring_s;
    logic [29:0] r_pixel;
    logic [14:0] r_ring;
    t_region     r_region;

    always_comb begin
        // The product already lies below 4*ir, so the wrap is a no-op.
        ipc    = r_p4_rair[RAIR_W-1 -: 16];
        pix_n  = 32'({r_p4_aa, 1'b0}) + 32'(ipc);
        pix_s  = 32'({r_p4_nn, 3'b000}) + 32'({r_p4_nn, 2'b00})
                 - 32'({r_p4_bb, 1'b0}) + 32'(ipc);
        ring_s = 16'({r_p4_n, 2'b00}) - 16'(r_p4_irc);
    end

    always_ff @(posedge i_clk) begin
        if (r_p4_belt) begin
            r_pixel  <= r_p4_pix_b[29:0];
            r_ring   <= r_p4_ring_b[14:0];
            r_region <= REGION_BELT;
        end else if (r_p4_zpos) begin
            r_pixel  <= pix_n[29:0];
            r_ring   <= 15'(r_p4_irc);
            r_region <= REGION_NORTH;
        end else begin
            r_pixel  <= pix_s[29:0];
            r_ring   <= ring_s[14:0];
            r_region <= REGION_SOUTH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
            r_pv <= '0;
        end else begin
            r_sv <= {r_sv[SQRT_STEPS-1:0], i_valid};
            r_pv <= {r_pv[3:0], r_sv[SQRT_STEPS]};
        end
    end

    assign o_valid  = r_pv[4];
    assign o_pixel  = r_pixel;
    assign o_ring   = r_ring;
    assign o_region = r_region;

endmodule

// File: rtl/healpix_ring_pixel_index.sv
// Ring-scheme sky pixel lookup.
// Requests enter on start with i_ra_turn and i_dec_quarter; one is taken at
// every rising edge where start is high and busy is low, so a new request may
// follow in every cycle. busy only rises if the four-entry request queue fills.
// Each request yields one result, shown on o_pixel, o_ring and o_region for
// exactly one cycle with o_valid high, in request order. The receiver cannot
// stall; the pipeline never holds back.
// The path runs through the queue hop, an input register and 30 CORDIC stages
// for sin(dec), a classify stage and 30 square-root stages for the polar caps,
// and five stages of index arithmetic.
// Throughput is one request per cycle while busy is low.
// nside is written through i_nside_we and i_nside; the user must write it
// only while no request is in flight, as the block does not enforce this.
// Zero reads as 1 and values above 8192 as 8192.
// Reset (synchronous, active low) empties the queue and pipeline valids and
// sets nside to 256.
`include "healpix_ring_pixel_index_defines.svh"

module healpix_ring_pixel_index import hpri_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ANGLE_BITS-1:0] i_ra_turn,
    input  logic [ANGLE_BITS:0]   i_dec_quarter,
    input  logic                  i_nside_we,
    input  logic [NSIDE_W-1:0]    i_nside,
    output logic                  o_valid,
    output logic [29:0]           o_pixel,
    output logic [14:0]           o_ring,
    output logic [1:0]            o_region
);

    logic [NSIDE_W-1:0] r_nside;
    logic [NSIDE_W-1:0] w_n_eff;
    t_qstat             w_qstat;
    logic               w_push;
    t_item              w_item;
    logic               w_q_valid;
    t_item              w_q_item;
    logic               w_z_valid;
    t_zitem             w_z;
    t_region            w_region;
    logic [14:0]        w_n15;
    logic               w_belt_out;
    logic               w_north_out;
    logic               w_belt_ring_ok;
    logic               w_north_ring_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nside <= NSIDE_W'(256);
        end else if (i_nside_we) begin
            r_nside <= i_nside;
        end
    end

    assign w_n_eff  = nside_eff(r_nside);
    assign busy     = w_qstat.full;
    assign o_region = w_region;

    hpri_front u_front (
        .i_start       (start),
        .i_ra_turn     (i_ra_turn),
        .i_dec_quarter (i_dec_quarter),
        .i_nside       (r_nside),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_item        (w_item)
    );

    hpri_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .o_stat  (w_qstat)
    );

    hpri_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_valid (w_z_valid),
        .o_z     (w_z)
    );

    hpri_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_z_valid),
        .i_z      (w_z),
        .o_valid  (o_valid),
        .o_pixel  (o_pixel),
        .o_ring   (o_ring),
        .o_region (w_region)
    );

    assign w_n15           = 15'(w_n_eff);
    assign w_belt_out      = o_valid && (w_region == REGION_BELT);
    assign w_north_out     = o_valid && (w_region == REGION_NORTH);
    assign w_belt_ring_ok  = (o_ring >= w_n15) && (o_ring <= 15'(3) * w_n15);
    assign w_north_ring_ok = (o_ring >= 15'd1) && (o_ring <= w_n15);

    `HPRI_CHECK(a_belt_ring, w_belt_out, w_belt_ring_ok, "belt ring outside nside..3*nside")
    `HPRI_CHECK(a_north_ring, w_north_out, w_north_ring_ok, "north cap ring outside 1..nside")
    `HPRI_CHECK_NEXT(a_queue_fill, start && !busy, !w_qstat.empty, "accepted request not queued")

endmodule
